### design/spb_pkg.sv
`timescale 1ns / 1ps

package spb_pkg;

  // Attribute table geometry (sprite_index is 6 bits, so up to 64 sprites)
  localparam int SpriteCount = 64;
  localparam int AddrW       = (SpriteCount > 1) ? $clog2(SpriteCount) : 1;

  // One table row is nine byte lanes: flags, x, y, width, height, palette 0..3
  localparam int LaneCount   = 9;
  localparam int LaneFlags   = 0;
  localparam int LanePal0    = 5;

  // Commands
  localparam logic CmdWriteAttr = 1'b0;
  localparam logic CmdDraw      = 1'b1;

  // Attribute byte offsets
  localparam logic [3:0] OffFlags  = 4'd0;
  localparam logic [3:0] OffX      = 4'd1;
  localparam logic [3:0] OffHeight = 4'd4;
  localparam logic [3:0] OffPal0   = 4'd7;
  localparam logic [3:0] OffPal3   = 4'd10;

  // Stored flag bits (upper nibble of the flags byte)
  localparam int FlagActive = 3;
  localparam int FlagTransp = 0;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CfgScreenWidth  = 2'd0;
  localparam cfg_idx_t CfgScreenHeight = 2'd1;
  localparam cfg_idx_t CfgLinePitch    = 2'd2;

  localparam logic [9:0] CfgResetValue = 10'd256;

  typedef logic [LaneCount-1:0][7:0] tbl_row_t;

  typedef struct packed {
    logic [3:0]      flags;
    logic [7:0]      height;
    logic [7:0]      width;
    logic [7:0]      y;
    logic [7:0]      x;
    logic [3:0][7:0] palette;
  } sprite_attr_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [AddrW-1:0] addr;
    logic [3:0]       offset;
    logic [7:0]       value;
  } tbl_req_t;

  typedef struct packed {
    logic       cmd;
    logic       in_range;
    logic [7:0] row;
    logic [5:0] column_byte;
    logic [7:0] pixel_byte;
  } draw_item_t;

  typedef struct packed {
    logic [19:0]     dest_addr;
    logic [3:0][7:0] colors;
    logic [3:0]      write_mask;
  } blit_result_t;

endpackage

### design/spb_attr_table.sv
`timescale 1ns / 1ps

module spb_attr_table (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spb_pkg::tbl_req_t     req_i,
  output spb_pkg::sprite_attr_t attr_o
);
  import spb_pkg::*;

  tbl_row_t               mem_q [SpriteCount];
  logic [SpriteCount-1:0] valid_q;
  tbl_row_t               rd_row_q;
  logic                   rd_vld_q;

  logic [LaneCount-1:0]   lane_hit;
  logic [LaneCount-1:0]   lane_we;
  logic [7:0]             byte_val;
  logic                   row_valid;

  // Offset to byte lane; source address bytes and unknown offsets hit nothing
  always_comb begin
    lane_hit = '0;
    byte_val = req_i.value;
    if (req_i.offset == OffFlags) begin
      lane_hit[LaneFlags] = 1'b1;
      byte_val = {4'b0000, req_i.value[7:4]};
    end else if (req_i.offset >= OffX && req_i.offset <= OffHeight) begin
      lane_hit[req_i.offset] = 1'b1;
    end else if (req_i.offset >= OffPal0 && req_i.offset <= OffPal3) begin
      lane_hit[req_i.offset - 4'(OffPal0 - LanePal0)] = 1'b1;
    end
  end

  // First write to a never-written row fills the other lanes with zero
  assign row_valid = valid_q[req_i.addr];

  always_comb begin
    for (int l = 0; l < LaneCount; l++) begin
      lane_we[l] = req_i.wr_en && (lane_hit[l] || ((|lane_hit) && !row_valid));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LaneCount; l++) begin
      if (lane_we[l]) begin
        mem_q[req_i.addr][l] <= lane_hit[l] ? byte_val : 8'h00;
      end
    end
    if (req_i.rd_en) begin
      rd_row_q <= mem_q[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en && (|lane_hit)) begin
        valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= row_valid;
      end
    end
  end

  // Rows never written read as all zero (inactive sprite)
  always_comb begin
    attr_o = '0;
    if (rd_vld_q) begin
      attr_o.flags   = rd_row_q[LaneFlags][3:0];
      attr_o.x       = rd_row_q[1];
      attr_o.y       = rd_row_q[2];
      attr_o.width   = rd_row_q[3];
      attr_o.height  = rd_row_q[4];
      for (int p = 0; p < 4; p++) begin
        attr_o.palette[p] = rd_row_q[LanePal0 + p];
      end
    end
  end

endmodule

### design/spb_draw_unit.sv
`timescale 1ns / 1ps

module spb_draw_unit (
  input  spb_pkg::draw_item_t   item_i,
  input  spb_pkg::sprite_attr_t attr_i,
  input  logic [9:0]            screen_width_i,
  input  logic [9:0]            screen_height_i,
  input  logic [9:0]            line_pitch_i,
  output spb_pkg::blit_result_t res_o
);
  import spb_pkg::*;

  logic        active;
  logic        transp;
  logic [8:0]  x_end;
  logic [8:0]  y_end;
  logic        on_screen;
  logic        in_sprite;
  logic [8:0]  line;
  logic [18:0] line_off;
  logic [19:0] addr;

  assign active    = attr_i.flags[FlagActive];
  assign transp    = attr_i.flags[FlagTransp];
  assign x_end     = {1'b0, attr_i.x} + {1'b0, attr_i.width};
  assign y_end     = {1'b0, attr_i.y} + {1'b0, attr_i.height};
  assign on_screen = ({1'b0, x_end} < screen_width_i) && ({1'b0, y_end} < screen_height_i);
  assign in_sprite = (item_i.row < attr_i.height) &&
                     (item_i.column_byte < attr_i.width[7:2]);
  assign line      = {1'b0, attr_i.y} + {1'b0, item_i.row};
  assign line_off  = 19'(line) * 19'(line_pitch_i);
  assign addr      = 20'(attr_i.x) + 20'({item_i.column_byte, 2'b00}) + 20'(line_off);

  always_comb begin
    res_o = '0;
    if (item_i.cmd == CmdDraw && item_i.in_range && active && on_screen && in_sprite) begin
      res_o.dest_addr = addr;
      for (int k = 0; k < 4; k++) begin
        res_o.colors[k]     = attr_i.palette[item_i.pixel_byte[2*k +: 2]];
        res_o.write_mask[k] = !(transp && (res_o.colors[k] == attr_i.palette[3]));
      end
    end
  end

endmodule

### design/sprite_pixel_blitter.sv
`timescale 1ns / 1ps

// An accepted request goes through stage 1 and then the result register to the outputs.
// Throughput: one request per cycle unless out_ready_i stalls; one attribute RAM access each.
// in_ready_o drops only while both the result register and the stage before it are full.
// Reset: control, valid bits of all 64 sprite rows (every sprite inactive) and the
// screen width, height and line pitch registers (256 each) are set at once, no clearing pass.
module sprite_pixel_blitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [5:0]  sprite_index_i,
  input  logic [3:0]  attr_offset_i,
  input  logic [7:0]  attr_value_i,
  input  logic [7:0]  row_i,
  input  logic [5:0]  column_byte_i,
  input  logic [7:0]  pixel_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [19:0] dest_addr_o,
  output logic [7:0]  color_a_o,
  output logic [7:0]  color_b_o,
  output logic [7:0]  color_c_o,
  output logic [7:0]  color_d_o,
  output logic [3:0]  write_mask_o
);
  import spb_pkg::*;

  // Configuration registers; the port never stalls
  logic [9:0] screen_width_q, screen_height_q, line_pitch_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= CfgResetValue;
      screen_height_q <= CfgResetValue;
      line_pitch_q    <= CfgResetValue;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgScreenWidth:  screen_width_q  <= cfg_data_i;
        CfgScreenHeight: screen_height_q <= cfg_data_i;
        CfgLinePitch:    line_pitch_q    <= cfg_data_i;
        default: ;  // unused index: write dropped
      endcase
    end
  end

  // Handshake. Stage 1 holds the accepted request next to the RAM read data;
  // the result register behind it frees the input side while a result waits.
  logic in_acc;
  logic s1_valid_q, s1_valid_d;
  logic s1_adv;
  logic out_valid_q, out_valid_d;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Attribute table access: writes and reads both happen at the accept edge,
  // so a draw right behind an attribute write already sees the new byte.
  logic         in_range;
  tbl_req_t     tbl_req;
  sprite_attr_t attr;

  assign in_range       = int'(sprite_index_i) < SpriteCount;
  assign tbl_req.wr_en  = in_acc && (command_i == CmdWriteAttr) && in_range;
  assign tbl_req.rd_en  = in_acc && (command_i == CmdDraw) && in_range;
  assign tbl_req.addr   = sprite_index_i[AddrW-1:0];
  assign tbl_req.offset = attr_offset_i;
  assign tbl_req.value  = attr_value_i;

  spb_attr_table u_attr_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .attr_o (attr)
  );

  // Stage 1 payload
  draw_item_t s1_item_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q.cmd         <= command_i;
      s1_item_q.in_range    <= in_range;
      s1_item_q.row         <= row_i;
      s1_item_q.column_byte <= column_byte_i;
      s1_item_q.pixel_byte  <= pixel_byte_i;
    end
  end

  // Clip, address and palette lookup
  blit_result_t res;

  spb_draw_unit u_draw_unit (
    .item_i          (s1_item_q),
    .attr_i          (attr),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .line_pitch_i    (line_pitch_q),
    .res_o           (res)
  );

  // Result register
  blit_result_t out_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dest_addr_o  = out_q.dest_addr;
  assign color_a_o    = out_q.colors[0];
  assign color_b_o    = out_q.colors[1];
  assign color_c_o    = out_q.colors[2];
  assign color_d_o    = out_q.colors[3];
  assign write_mask_o = out_q.write_mask;

`ifndef SYNTHESIS
  a_write_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (s1_item_q.cmd == CmdWriteAttr) |-> (res == '0))
    else $error("attribute write request produced a nonzero result");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted request missing from stage 1");

  a_s1_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |=> s1_valid_q && $stable(s1_item_q))
    else $error("stage 1 request lost while result stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with empty pipeline");
`endif

endmodule

### sim/tb_sprite_pixel_blitter.sv
`timescale 1ns / 1ps

module tb_sprite_pixel_blitter;
  import spb_pkg::*;

  // Attribute offsets the package leaves unnamed
  localparam logic [3:0] OffY      = 4'd2;
  localparam logic [3:0] OffWidth  = 4'd3;
  localparam logic [3:0] OffSrcLo  = 4'd5;
  localparam logic [3:0] OffSrcHi  = 4'd6;
  localparam logic [3:0] OffPal1   = 4'd8;
  localparam logic [3:0] OffPal2   = 4'd9;
  localparam logic [3:0] OffBeyond = 4'd15;  // above the last palette byte, dropped

  // Index 3 of the config channel maps to no register
  localparam cfg_idx_t CfgSpare = 2'd3;

  // Flags byte as written: bit7 active, bit6/5 flips, bit4 transparency
  localparam logic [7:0] FlagsShowKeyed = 8'h90;
  localparam logic [7:0] FlagsShowFlip  = 8'hE0;
  localparam logic [7:0] FlagsShow      = 8'h80;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 4;    // margin after the last result is checked
  localparam int MixPerPhase   = 100;
  localparam int PoolSize      = 4;
  localparam int PhaseCount    = 5;
  localparam int ShowLimit     = 10;

  typedef struct packed {
    logic       cmd;
    logic [5:0] idx;
    logic [3:0] off;
    logic [7:0] val;
    logic [7:0] row;
    logic [5:0] col;
    logic [7:0] pix;
  } blit_req_t;

  typedef struct packed {
    logic [19:0]     dest;
    logic [3:0][7:0] colors;   // colors[0] is the first pixel
    logic [3:0]      mask;
  } blit_out_t;

  localparam blit_out_t NoPixels = '0;

  typedef struct {
    blit_req_t req;
    bit        known;   // result typed in below rather than predicted
    blit_out_t res;
  } dir_row_t;

  // Directed requests, default screen (256 x 256, pitch 256).
  // Sprite 5 is built up to cover the full screen range, sprite 6 is never
  // touched, sprite 7 ends up hanging off the right edge.
  dir_row_t directed [24] = '{
    // draw right after reset: every sprite is inactive
    '{'{CmdDraw,      6'd0, OffFlags,  8'h00,          8'd0,   6'd0,  8'h00}, 1'b1, NoPixels},
    '{'{CmdWriteAttr, 6'd5, OffFlags,  FlagsShowKeyed, 8'd0,   6'd0,  8'h00}, 1'b1, NoPixels},
    '{'{CmdWriteAttr, 6'd5, OffX,      8'd0,           8'd0,   6'd0,  8'h00}, 1'b1, NoPixels},
    '{'{CmdWriteAttr, 6'd5, OffY,      8'd0,           8'd0,   6'd0,  8'h00}, 1'b1, NoPixels},
    '{'{CmdWriteAttr, 6'd5, OffWidth,  8'd252,         8'd0,   6'd0,  8'h00}, 1'b1, NoPixels},
    '{'{CmdWriteAttr, 6'd5, OffHeight, 8'd255,         8'd0,   6'd0,  8'h00}, 1'b1, NoPixels},
    '{'{CmdWriteAttr, 6'd5, OffPal0,   8'h00,          8'd0,   6'd0,  8'h00}, 1'b1, NoPixels},
    '{'{CmdWriteAttr, 6'd5, OffPal1,   8'h55,          8'd0,   6'd0,  8'h00}, 1'b1, NoPixels},
    '{'{CmdWriteAttr, 6'd5, OffPal2,   8'hAA,          8'd0,   6'd0,  8'h00}, 1'b1, NoPixels},
    '{'{CmdWriteAttr, 6'd5, OffPal3,   8'hFF,          8'd0,   6'd0,  8'h00}, 1'b1, NoPixels},
    // source address bytes: taken, not stored
    '{'{CmdWriteAttr, 6'd5, OffSrcLo,  8'h12,          8'd0,   6'd0,  8'h00}, 1'b1, NoPixels},
    '{'{CmdWriteAttr, 6'd5, OffSrcHi,  8'h34,          8'd0,   6'd0,  8'h00}, 1'b1, NoPixels},
    // offset past the palette: ignored
    '{'{CmdWriteAttr, 6'd5, OffBeyond, 8'hFF,          8'd0,   6'd0,  8'h00}, 1'b1, NoPixels},
    // one pixel of each index, index 3 is the key color
    '{'{CmdDraw,      6'd5, OffFlags,  8'h00,          8'd0,   6'd0,  8'hE4}, 1'b1,
      '{20'd0, 32'hFFAA5500, 4'b0111}},
    // far corner, all four pixels keyed out
    '{'{CmdDraw,      6'd5, OffFlags,  8'h00,          8'd254, 6'd62, 8'hFF}, 1'b0, NoPixels},
    // row one past the sprite bottom: clipped
    '{'{CmdDraw,      6'd5, OffFlags,  8'h00,          8'd255, 6'd0,  8'h1B}, 1'b1, NoPixels},
    '{'{CmdDraw,      6'd5, OffFlags,  8'h00,          8'd0,   6'd63, 8'h00}, 1'b0, NoPixels},
    // flips on, transparency off: flips change nothing, all pixels written
    '{'{CmdWriteAttr, 6'd5, OffFlags,  FlagsShowFlip,  8'd0,   6'd0,  8'h00}, 1'b1, NoPixels},
    '{'{CmdDraw,      6'd5, OffFlags,  8'h00,          8'd17,  6'd9,  8'hFF}, 1'b0, NoPixels},
    // never-written sprite
    '{'{CmdDraw,      6'd6, OffFlags,  8'h00,          8'd0,   6'd0,  8'h27}, 1'b1, NoPixels},
    // x + width runs past the screen edge
    '{'{CmdWriteAttr, 6'd7, OffFlags,  FlagsShow,      8'd0,   6'd0,  8'h00}, 1'b1, NoPixels},
    '{'{CmdWriteAttr, 6'd7, OffWidth,  8'd8,           8'd0,   6'd0,  8'h00}, 1'b1, NoPixels},
    '{'{CmdWriteAttr, 6'd7, OffX,      8'd250,         8'd0,   6'd0,  8'h00}, 1'b1, NoPixels},
    '{'{CmdDraw,      6'd7, OffFlags,  8'h00,          8'd0,   6'd0,  8'h1B}, 1'b1, NoPixels}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [9:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        command_i;
  logic [5:0]  sprite_index_i;
  logic [3:0]  attr_offset_i;
  logic [7:0]  attr_value_i;
  logic [7:0]  row_i;
  logic [5:0]  column_byte_i;
  logic [7:0]  pixel_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [19:0] dest_addr_o;
  logic [7:0]  color_a_o;
  logic [7:0]  color_b_o;
  logic [7:0]  color_c_o;
  logic [7:0]  color_d_o;
  logic [3:0]  write_mask_o;

  sprite_pixel_blitter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .sprite_index_i (sprite_index_i),
    .attr_offset_i  (attr_offset_i),
    .attr_value_i   (attr_value_i),
    .row_i          (row_i),
    .column_byte_i  (column_byte_i),
    .pixel_byte_i   (pixel_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dest_addr_o    (dest_addr_o),
    .color_a_o      (color_a_o),
    .color_b_o      (color_b_o),
    .color_c_o      (color_c_o),
    .color_d_o      (color_d_o),
    .write_mask_o   (write_mask_o)
  );

  // Shadow of the block: screen registers and the attribute table
  logic [9:0] scr_w;
  logic [9:0] scr_h;
  logic [9:0] pitch;
  logic [3:0] sp_flags [SpriteCount];
  logic [7:0] sp_x     [SpriteCount];
  logic [7:0] sp_y     [SpriteCount];
  logic [7:0] sp_w     [SpriteCount];
  logic [7:0] sp_h     [SpriteCount];
  logic [7:0] sp_pal   [SpriteCount][4];

  blit_out_t expected_blits [$];
  blit_out_t known_res;       // typed-in result for the request being driven
  bit        known_now;
  blit_out_t got;
  blit_out_t want;
  blit_out_t model;
  int        fail_count;
  int        shown;
  int        burst_left;
  int        pool [PoolSize];  // sprites most traffic goes to in a phase

  // Applies one request to the shadow and returns the pixels it should yield
  function automatic blit_out_t blit_pixels(blit_req_t r);
    blit_out_t  o;
    logic [7:0] c;
    int         base;
    int         k;
    o = NoPixels;
    if (r.cmd == CmdWriteAttr) begin
      if (r.off == OffFlags) sp_flags[r.idx] = r.val[7:4];
      else if (r.off == OffX) sp_x[r.idx] = r.val;
      else if (r.off == OffY) sp_y[r.idx] = r.val;
      else if (r.off == OffWidth) sp_w[r.idx] = r.val;
      else if (r.off == OffHeight) sp_h[r.idx] = r.val;
      else if (r.off >= OffPal0 && r.off <= OffPal3) sp_pal[r.idx][r.off - OffPal0] = r.val;
      return o;
    end
    if (!sp_flags[r.idx][FlagActive]) return o;
    // sprite must sit strictly inside the screen
    if (int'(sp_x[r.idx]) + int'(sp_w[r.idx]) >= int'(scr_w) ||
        int'(sp_y[r.idx]) + int'(sp_h[r.idx]) >= int'(scr_h)) return o;
    // clip against the sprite's own extent; width counts pixels, column counts bytes
    if (r.row >= sp_h[r.idx] || int'(r.col) >= int'(sp_w[r.idx] >> 2)) return o;
    base = int'(sp_x[r.idx]) + 4 * int'(r.col) +
           (int'(sp_y[r.idx]) + int'(r.row)) * int'(pitch);
    o.dest = base[19:0];
    for (k = 0; k < 4; k++) begin
      c = sp_pal[r.idx][r.pix[2*k +: 2]];
      o.colors[k] = c;
      o.mask[k] = !(sp_flags[r.idx][FlagTransp] && c == sp_pal[r.idx][3]);
    end
    return o;
  endfunction

  // Start or extent that keeps the sprite on screen given the other coordinate
  function automatic logic [7:0] fit_span(int other, int limit);
    int room;
    room = limit - 1 - other;
    if (room < 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, (room > 255) ? 255 : room));
  endfunction

  // Attribute byte biased toward sprites that are active and on screen
  function automatic logic [7:0] attr_value_for(int idx, logic [3:0] off);
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    if (off == OffFlags) return 8'($urandom_range(0, 255)) | FlagsShow;
    if (off == OffX) return fit_span(sp_w[idx], scr_w);
    if (off == OffWidth) return fit_span(sp_x[idx], scr_w);
    if (off == OffY) return fit_span(sp_h[idx], scr_h);
    if (off == OffHeight) return fit_span(sp_y[idx], scr_h);
    return 8'($urandom_range(0, 255));
  endfunction

  // Random traffic: mostly in-range draws on the pool, some attribute updates,
  // some stray offsets, rows, columns and sprites
  function automatic blit_req_t mixed_req();
    blit_req_t r;
    int        idx;
    int        cols;
    idx = ($urandom_range(0, 9) != 0) ? pool[$urandom_range(0, PoolSize - 1)]
                                      : int'($urandom_range(0, 63));
    r = '{CmdDraw, 6'(idx), 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
          8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255))};
    if ($urandom_range(0, 99) < 25) begin
      r.cmd = CmdWriteAttr;
      if ($urandom_range(0, 6) != 0) r.off = 4'($urandom_range(0, 10));
      r.val = attr_value_for(idx, r.off);
    end else begin
      cols = int'(sp_w[idx] >> 2);
      if (sp_h[idx] != 0 && $urandom_range(0, 6) != 0)
        r.row = 8'($urandom_range(0, int'(sp_h[idx]) - 1));
      if (cols != 0 && $urandom_range(0, 6) != 0)
        r.col = 6'($urandom_range(0, cols - 1));
    end
    return r;
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (shown < ShowLimit) begin
      shown++;
      $display("%0t: %s", $time, what);
    end
  endtask

  // One request on the input channel; valid stays up after the accept so a
  // following request goes out back to back
  task automatic send_req(input blit_req_t r, input bit known, input blit_out_t res);
    @(negedge clk_i);
    {command_i, sprite_index_i, attr_offset_i, attr_value_i,
     row_i, column_byte_i, pixel_byte_i} = r;
    known_now  = known;
    known_res  = res;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Sender bursts: short or long runs, separated by random gaps
  task automatic pace();
    if (burst_left == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // Hold off the sender until every result is back and the pipe is quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_blits.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [9:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver stalls: each stretch picks one of always ready, coin flip,
  // alternating, or mostly stalled
  initial begin
    int mode;
    out_ready_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 80)) begin
        @(negedge clk_i);
        case (mode)
          0: out_ready_i = 1'b1;
          1: out_ready_i = 1'($urandom_range(0, 1));
          2: out_ready_i = !out_ready_i;
          default: out_ready_i = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Scoreboard: results are checked before the same edge's request is
  // predicted; config accepts update the shadow registers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{dest_addr_o, {color_d_o, color_c_o, color_b_o, color_a_o}, write_mask_o};
        if (expected_blits.size() == 0) begin
          note_failure($sformatf("result with nothing pending: addr %05h colors %08h mask %h",
                                 got.dest, got.colors, got.mask));
        end else begin
          want = expected_blits.pop_front();
          if (got.dest !== want.dest || got.colors !== want.colors || got.mask !== want.mask)
            note_failure($sformatf(
              "mismatch: expected addr %05h colors %08h mask %h, got addr %05h colors %08h mask %h",
              want.dest, want.colors, want.mask, got.dest, got.colors, got.mask));
        end
      end
      if (in_valid_i && in_ready_o) begin
        model = blit_pixels('{command_i, sprite_index_i, attr_offset_i, attr_value_i,
                              row_i, column_byte_i, pixel_byte_i});
        expected_blits.push_back(known_now ? known_res : model);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgScreenWidth) scr_w = cfg_data_i;
        else if (cfg_index_i == CfgScreenHeight) scr_h = cfg_data_i;
        else if (cfg_index_i == CfgLinePitch) pitch = cfg_data_i;
      end
    end
  end

  // Watchdog: too long without any handshake on any channel
  initial begin
    int idle;
    idle = 0;
    while (idle < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) idle = 0;
      else idle++;
    end
    $display("%0t: no handshake for %0d cycles", $time, WatchdogLimit);
    $display("** sprite_pixel_blitter: FAILED **");
    $finish;
  end

  initial begin
    int phase;
    int k;
    int o;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CfgScreenWidth;
    cfg_data_i     = '0;
    command_i      = CmdWriteAttr;
    sprite_index_i = '0;
    attr_offset_i  = OffFlags;
    attr_value_i   = '0;
    row_i          = '0;
    column_byte_i  = '0;
    pixel_byte_i   = '0;
    known_now      = 1'b0;
    known_res      = NoPixels;
    fail_count     = 0;
    shown          = 0;
    burst_left     = 0;
    scr_w          = CfgResetValue;
    scr_h          = CfgResetValue;
    pitch          = CfgResetValue;
    for (k = 0; k < SpriteCount; k++) begin
      sp_flags[k] = '0;
      sp_x[k]     = '0;
      sp_y[k]     = '0;
      sp_w[k]     = '0;
      sp_h[k]     = '0;
      for (o = 0; o < 4; o++) sp_pal[k][o] = '0;
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, back to back
    foreach (directed[i]) send_req(directed[i].req, directed[i].known, directed[i].res);

    // Random phases; registers change only once the block has drained
    for (phase = 0; phase < PhaseCount; phase++) begin
      settle();
      case (phase)
        0: ;  // stay on the reset screen
        1: begin
          write_reg(CfgScreenWidth, 10'd1023);
          write_reg(CfgScreenHeight, 10'd1023);
          write_reg(CfgLinePitch, 10'd1023);
          write_reg(CfgSpare, 10'($urandom_range(0, 1023)));  // must change nothing
        end
        2: begin
          // one-pixel screen: everything is clipped
          write_reg(CfgScreenWidth, 10'd1);
          write_reg(CfgScreenHeight, 10'd1);
          write_reg(CfgLinePitch, 10'd1);
        end
        3: begin
          write_reg(CfgScreenWidth, 10'($urandom_range(1, 1023)));
          write_reg(CfgScreenHeight, 10'($urandom_range(1, 1023)));
          write_reg(CfgLinePitch, 10'($urandom_range(1, 1023)));
        end
        default: begin
          write_reg(CfgLinePitch, 10'($urandom_range(240, 1023)));
          write_reg(CfgScreenHeight, 10'($urandom_range(240, 1023)));
          write_reg(CfgScreenWidth, 10'($urandom_range(240, 1023)));
        end
      endcase

      // Build up every attribute byte of the pool sprites, then mixed traffic
      for (k = 0; k < PoolSize; k++) pool[k] = $urandom_range(0, 63);
      for (k = 0; k < PoolSize; k++) begin
        for (o = 0; o <= int'(OffPal3); o++) begin
          pace();
          send_req('{CmdWriteAttr, 6'(pool[k]), 4'(o), attr_value_for(pool[k], 4'(o)),
                     8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                     8'($urandom_range(0, 255))}, 1'b0, NoPixels);
        end
      end
      repeat (MixPerPhase) begin
        pace();
        send_req(mixed_req(), 1'b0, NoPixels);
      end
    end

    settle();
    if (fail_count == 0) $display("** sprite_pixel_blitter: PASSED **");
    else $display("** sprite_pixel_blitter: FAILED **");
    $finish;
  end

endmodule
